### sv/ffp_pkg.sv
// Package for the frame-from-three-points pipeline: widths, beat structs,
// sideband struct and small helper functions. No dependencies.
`default_nettype none
package ffp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int PRE_SHIFT   = (COORD_WIDTH > 62) ? COORD_WIDTH - 62 : 0;
  localparam int TOL_W       = 31;
  localparam int AXIS_W      = 32;
  localparam int MAG_W       = 30;
  localparam int ISQ_N       = 32;
  localparam int ISQ_TOP     = 62;
  localparam int DIV_N       = 32;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(128);
  localparam logic [33:0]      ONE_Q30   = 34'd1 << 30;

  typedef logic signed [63:0]           wide_t;
  typedef wide_t [2:0]                  wvec_t;
  typedef logic signed [AXIS_W-1:0]     q30_t;
  typedef q30_t [2:0]                   axis_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [2:0][MAG_W-1:0]        mag3_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t xdir_point_x;
    coord_t xdir_point_y;
    coord_t xdir_point_z;
    coord_t ydir_point_x;
    coord_t ydir_point_y;
    coord_t ydir_point_z;
  } ffp_in_t;

  typedef struct packed {
    q30_t axis_x_x;
    q30_t axis_x_y;
    q30_t axis_x_z;
    q30_t axis_y_x;
    q30_t axis_y_y;
    q30_t axis_y_z;
    q30_t axis_z_x;
    q30_t axis_z_y;
    q30_t axis_z_z;
    logic frame_valid;
  } ffp_out_t;

  typedef struct packed {
    logic  ok;
    axis_t ux;
    axis_t uy;
    axis_t uz;
  } side_t;

  function automatic wide_t coord_ext(coord_t c);
    wide_t w;
    w = 64'(c);
    return w >>> PRE_SHIFT;
  endfunction

  function automatic logic [6:0] bit_len(logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### sv/ffp_norm.sv
// Vector normalize pipeline: magnitude scaling, sum of squares, pipelined
// square root and three pipelined restoring dividers. Uses ffp_pkg.
`default_nettype none
module ffp_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_i,
  input  ffp_pkg::wvec_t vec_i,
  input  ffp_pkg::side_t side_i,
  output logic           valid_o,
  output ffp_pkg::axis_t unit_o,
  output logic           nz_o,
  output ffp_pkg::side_t side_o
);
  import ffp_pkg::*;

  logic              a_v_r;
  logic [2:0][63:0]  a_mag_r, a_mag_nxt;
  logic [2:0]        a_neg_r, a_neg_nxt;
  logic [63:0]       a_or_r, a_or_nxt;
  side_t             a_side_r;

  logic              b_v_r;
  logic [2:0][63:0]  b_mag_r;
  logic [2:0]        b_neg_r;
  logic [6:0]        b_len_r;
  logic              b_z_r;
  side_t             b_side_r;

  logic              c_v_r;
  mag3_t             c_m_r, c_m_nxt;
  logic [63:0]       c_sh;
  logic [2:0]        c_neg_r;
  logic              c_z_r;
  side_t             c_side_r;

  logic              d_v_r;
  logic [2:0][59:0]  d_sq_r, d_sq_nxt;
  mag3_t             d_m_r;
  logic [2:0]        d_neg_r;
  logic              d_z_r;
  side_t             d_side_r;

  logic              s_v_r    [ISQ_N+1];
  logic [63:0]       s_x_r    [ISQ_N+1];
  logic [63:0]       s_root_r [ISQ_N+1];
  mag3_t             s_m_r    [ISQ_N+1];
  logic [2:0]        s_neg_r  [ISQ_N+1];
  logic              s_z_r    [ISQ_N+1];
  side_t             s_side_r [ISQ_N+1];

  logic              q_v_r    [DIV_N+1];
  logic [2:0][63:0]  q_rem_r  [DIV_N+1];
  logic [31:0]       q_n_r    [DIV_N+1];
  logic [2:0][31:0]  q_q_r    [DIV_N+1];
  logic [2:0]        q_neg_r  [DIV_N+1];
  logic              q_z_r    [DIV_N+1];
  side_t             q_side_r [DIV_N+1];

  logic [2:0][63:0]  q_rem_nxt;
  logic [31:0]       root_n;

  // stage A: magnitudes and sign
  always_comb begin
    a_or_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      a_neg_nxt[i] = vec_i[i][63];
      a_mag_nxt[i] = a_neg_nxt[i] ? (~vec_i[i] + 64'd1) : vec_i[i];
      a_or_nxt     = a_or_nxt | a_mag_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= valid_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r  <= a_mag_nxt;
      a_neg_r  <= a_neg_nxt;
      a_or_r   <= a_or_nxt;
      a_side_r <= side_i;
    end
  end

  // stage B: bit length of the largest magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (en) b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mag_r  <= a_mag_r;
      b_neg_r  <= a_neg_r;
      b_len_r  <= bit_len(a_or_r);
      b_z_r    <= (a_or_r == '0);
      b_side_r <= a_side_r;
    end
  end

  // stage C: common scale, largest magnitude into [2^29, 2^30)
  always_comb begin
    c_sh = '0;
    for (int i = 0; i < 3; i++) begin
      if (b_len_r > 7'd30) c_sh = b_mag_r[i] >> (b_len_r - 7'd30);
      else c_sh = b_mag_r[i] << (7'd30 - b_len_r);
      c_m_nxt[i] = c_sh[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (en) c_v_r <= b_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_m_r    <= c_m_nxt;
      c_neg_r  <= b_neg_r;
      c_z_r    <= b_z_r;
      c_side_r <= b_side_r;
    end
  end

  // stage D: squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_sq_nxt[i] = 60'(c_m_r[i]) * 60'(c_m_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (en) d_v_r <= c_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_sq_r   <= d_sq_nxt;
      d_m_r    <= c_m_r;
      d_neg_r  <= c_neg_r;
      d_z_r    <= c_z_r;
      d_side_r <= c_side_r;
    end
  end

  // stage E: sum of squares
  always_ff @(posedge clk) begin
    if (!rst_n) s_v_r[0] <= 1'b0;
    else if (en) s_v_r[0] <= d_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_x_r[0]    <= 64'(d_sq_r[0]) + 64'(d_sq_r[1]) + 64'(d_sq_r[2]);
      s_root_r[0] <= '0;
      s_m_r[0]    <= d_m_r;
      s_neg_r[0]  <= d_neg_r;
      s_z_r[0]    <= d_z_r;
      s_side_r[0] <= d_side_r;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < ISQ_N; k++) begin : g_isq
    localparam logic [63:0] BIT = 64'd1 << (ISQ_TOP - 2 * k);
    logic [63:0] trial;
    logic [63:0] x_nxt;
    logic [63:0] root_nxt;

    always_comb begin
      trial = s_root_r[k] + BIT;
      if (s_x_r[k] >= trial) begin
        x_nxt    = s_x_r[k] - trial;
        root_nxt = (s_root_r[k] >> 1) + BIT;
      end else begin
        x_nxt    = s_x_r[k];
        root_nxt = s_root_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) s_v_r[k+1] <= 1'b0;
      else if (en) s_v_r[k+1] <= s_v_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_x_r[k+1]    <= x_nxt;
        s_root_r[k+1] <= root_nxt;
        s_m_r[k+1]    <= s_m_r[k];
        s_neg_r[k+1]  <= s_neg_r[k];
        s_z_r[k+1]    <= s_z_r[k];
        s_side_r[k+1] <= s_side_r[k];
      end
    end
  end

  // divider load: rounded dividend
  assign root_n = s_root_r[ISQ_N][31:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_rem_nxt[i] = {4'd0, s_m_r[ISQ_N][i], 30'd0} + 64'(root_n >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_v_r[0] <= 1'b0;
    else if (en) q_v_r[0] <= s_v_r[ISQ_N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_rem_r[0]  <= q_rem_nxt;
      q_n_r[0]    <= root_n;
      q_q_r[0]    <= '0;
      q_neg_r[0]  <= s_neg_r[ISQ_N];
      q_z_r[0]    <= s_z_r[ISQ_N];
      q_side_r[0] <= s_side_r[ISQ_N];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    localparam int SH = DIV_N - 1 - j;
    logic [63:0]      dv;
    logic [2:0][63:0] rem_nxt;
    logic [2:0][31:0] quo_nxt;

    always_comb begin
      dv = 64'(q_n_r[j]) << SH;
      for (int i = 0; i < 3; i++) begin
        if (q_rem_r[j][i] >= dv) begin
          rem_nxt[i] = q_rem_r[j][i] - dv;
          quo_nxt[i] = q_q_r[j][i] | (32'd1 << SH);
        end else begin
          rem_nxt[i] = q_rem_r[j][i];
          quo_nxt[i] = q_q_r[j][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) q_v_r[j+1] <= 1'b0;
      else if (en) q_v_r[j+1] <= q_v_r[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_rem_r[j+1]  <= rem_nxt;
        q_n_r[j+1]    <= q_n_r[j];
        q_q_r[j+1]    <= quo_nxt;
        q_neg_r[j+1]  <= q_neg_r[j];
        q_z_r[j+1]    <= q_z_r[j];
        q_side_r[j+1] <= q_side_r[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_o[i] = q_neg_r[DIV_N][i] ? (32'd0 - q_q_r[DIV_N][i]) : q_q_r[DIV_N][i];
    end
  end

  assign valid_o = q_v_r[DIV_N];
  assign nz_o    = !q_z_r[DIV_N];
  assign side_o  = q_side_r[DIV_N];

endmodule
`default_nettype wire

### sv/ffp_cross.sv
// Cross product of two Q2.30 axes into exact wide components, two stages.
// Uses ffp_pkg.
`default_nettype none
module ffp_cross (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_i,
  input  ffp_pkg::axis_t a_i,
  input  ffp_pkg::axis_t b_i,
  input  ffp_pkg::side_t side_i,
  output logic           valid_o,
  output ffp_pkg::wvec_t vec_o,
  output ffp_pkg::side_t side_o
);
  import ffp_pkg::*;

  logic        p_v_r;
  wide_t [5:0] p_r, p_nxt;
  side_t       p_side_r;
  logic        v_v_r;
  wvec_t       v_r;
  side_t       v_side_r;

  always_comb begin
    p_nxt[0] = 64'($signed(a_i[1])) * 64'($signed(b_i[2]));
    p_nxt[1] = 64'($signed(a_i[2])) * 64'($signed(b_i[1]));
    p_nxt[2] = 64'($signed(a_i[2])) * 64'($signed(b_i[0]));
    p_nxt[3] = 64'($signed(a_i[0])) * 64'($signed(b_i[2]));
    p_nxt[4] = 64'($signed(a_i[0])) * 64'($signed(b_i[1]));
    p_nxt[5] = 64'($signed(a_i[1])) * 64'($signed(b_i[0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      v_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= valid_i;
      v_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r      <= p_nxt;
      p_side_r <= side_i;
      v_r[0]   <= p_r[0] - p_r[1];
      v_r[1]   <= p_r[2] - p_r[3];
      v_r[2]   <= p_r[4] - p_r[5];
      v_side_r <= p_side_r;
    end
  end

  assign valid_o = v_v_r;
  assign vec_o   = v_r;
  assign side_o  = v_side_r;

endmodule
`default_nettype wire

### sv/ffp_dot.sv
// Near-parallel check: dot product of the unit edges, rounding and
// tolerance compare over four stages. Uses ffp_pkg.
`default_nettype none
module ffp_dot (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_i,
  input  ffp_pkg::side_t            side_i,
  input  logic [ffp_pkg::TOL_W-1:0] tol_i,
  output logic                      valid_o,
  output ffp_pkg::side_t            side_o
);
  import ffp_pkg::*;

  logic        p_v_r, s_v_r, m_v_r, k_v_r;
  wide_t [2:0] p_r, p_nxt;
  wide_t       s_r;
  logic [63:0] m_abs;
  logic [33:0] m_r;
  side_t       p_side_r, s_side_r, m_side_r, k_side_r, k_side_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_nxt[i] = 64'($signed(side_i.ux[i])) * 64'($signed(side_i.uy[i]));
    end
    m_abs = s_r[63] ? (~s_r + 64'd1) : s_r;
  end

  always_comb begin
    k_side_nxt    = m_side_r;
    k_side_nxt.ok = m_side_r.ok && (m_r <= ONE_Q30) &&
                    ((ONE_Q30 - m_r) >= 34'(tol_i));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      s_v_r <= 1'b0;
      m_v_r <= 1'b0;
      k_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= valid_i;
      s_v_r <= p_v_r;
      m_v_r <= s_v_r;
      k_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r      <= p_nxt;
      p_side_r <= side_i;
      s_r      <= p_r[0] + p_r[1] + p_r[2];
      s_side_r <= p_side_r;
      m_r      <= 34'((m_abs + (64'd1 << 29)) >> 30);
      m_side_r <= s_side_r;
      k_side_r <= k_side_nxt;
    end
  end

  assign valid_o = k_v_r;
  assign side_o  = k_side_r;

endmodule
`default_nettype wire

### sv/frame_from_three_points.sv
// Throughput: one beat per cycle while the output is not stalled; the
// pipeline is four normalize units (two in parallel), a dot check and two
// cross products, all fully staged.
// A stalled output beat holds every stage in place.
// Reset (synchronous, active low) clears all valid bits and sets the
// parallel tolerance to 128.
`default_nettype none
module frame_from_three_points (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ffp_pkg::TOL_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ffp_pkg::ffp_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ffp_pkg::ffp_out_t         out_data
);
  import ffp_pkg::*;

  logic             en;
  logic [TOL_W-1:0] tol_r;
  logic             fr_v_r;
  wvec_t            fr_ex_r, fr_ey_r, fr_ex_nxt, fr_ey_nxt;
  side_t            fr_side;

  logic  nx_valid, nx_nz, ny_nz;
  axis_t nx_unit, ny_unit;
  side_t nx_side, xy_side;

  logic  dt_valid;
  side_t dt_side;

  logic  c1_valid;
  wvec_t c1_vec;
  side_t c1_side;

  logic  z_valid, z_nz;
  axis_t z_unit;
  side_t z_side, zs_side;

  logic  c2_valid;
  wvec_t c2_vec;
  side_t c2_side;

  logic  f_valid, f_nz, f_ok;
  axis_t f_unit;
  side_t f_side;

  logic     out_valid_r;
  ffp_out_t out_data_r, out_data_nxt;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= TOL_RESET;
    else if (cfg_we) tol_r <= cfg_wdata;
  end

  // edge vectors
  always_comb begin
    fr_ex_nxt[0] = coord_ext(in_data.xdir_point_x) - coord_ext(in_data.origin_x);
    fr_ex_nxt[1] = coord_ext(in_data.xdir_point_y) - coord_ext(in_data.origin_y);
    fr_ex_nxt[2] = coord_ext(in_data.xdir_point_z) - coord_ext(in_data.origin_z);
    fr_ey_nxt[0] = coord_ext(in_data.ydir_point_x) - coord_ext(in_data.origin_x);
    fr_ey_nxt[1] = coord_ext(in_data.ydir_point_y) - coord_ext(in_data.origin_y);
    fr_ey_nxt[2] = coord_ext(in_data.ydir_point_z) - coord_ext(in_data.origin_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fr_v_r <= 1'b0;
    else if (en) fr_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr_ex_r <= fr_ex_nxt;
      fr_ey_r <= fr_ey_nxt;
    end
  end

  assign fr_side = '{ok: 1'b1, default: '0};

  ffp_norm u_norm_x (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(fr_v_r), .vec_i(fr_ex_r), .side_i(fr_side),
    .valid_o(nx_valid), .unit_o(nx_unit), .nz_o(nx_nz), .side_o(nx_side)
  );

  ffp_norm u_norm_y (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(fr_v_r), .vec_i(fr_ey_r), .side_i(fr_side),
    .valid_o(), .unit_o(ny_unit), .nz_o(ny_nz), .side_o()
  );

  always_comb begin
    xy_side    = nx_side;
    xy_side.ok = nx_side.ok && nx_nz && ny_nz;
    xy_side.ux = nx_unit;
    xy_side.uy = ny_unit;
  end

  ffp_dot u_dot (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(nx_valid), .side_i(xy_side), .tol_i(tol_r),
    .valid_o(dt_valid), .side_o(dt_side)
  );

  ffp_cross u_cross_z (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(dt_valid), .a_i(dt_side.ux), .b_i(dt_side.uy), .side_i(dt_side),
    .valid_o(c1_valid), .vec_o(c1_vec), .side_o(c1_side)
  );

  ffp_norm u_norm_z (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(c1_valid), .vec_i(c1_vec), .side_i(c1_side),
    .valid_o(z_valid), .unit_o(z_unit), .nz_o(z_nz), .side_o(z_side)
  );

  always_comb begin
    zs_side    = z_side;
    zs_side.ok = z_side.ok && z_nz;
    zs_side.uz = z_unit;
  end

  ffp_cross u_cross_y (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(z_valid), .a_i(zs_side.uz), .b_i(zs_side.ux), .side_i(zs_side),
    .valid_o(c2_valid), .vec_o(c2_vec), .side_o(c2_side)
  );

  ffp_norm u_norm_f (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(c2_valid), .vec_i(c2_vec), .side_i(c2_side),
    .valid_o(f_valid), .unit_o(f_unit), .nz_o(f_nz), .side_o(f_side)
  );

  // drop the axes of a rejected frame
  assign f_ok = f_side.ok && f_nz;

  always_comb begin
    out_data_nxt             = '0;
    out_data_nxt.frame_valid = f_ok;
    if (f_ok) begin
      out_data_nxt.axis_x_x = f_side.ux[0];
      out_data_nxt.axis_x_y = f_side.ux[1];
      out_data_nxt.axis_x_z = f_side.ux[2];
      out_data_nxt.axis_y_x = f_unit[0];
      out_data_nxt.axis_y_y = f_unit[1];
      out_data_nxt.axis_y_z = f_unit[2];
      out_data_nxt.axis_z_x = f_side.uz[0];
      out_data_nxt.axis_z_y = f_side.uz[1];
      out_data_nxt.axis_z_z = f_side.uz[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= f_valid;
  end

  always_ff @(posedge clk) begin
    if (en) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### sv/ffp_chk.sv
// Port-level checker for frame_from_three_points and its bind statement.
// Uses ffp_pkg.
`default_nettype none
module ffp_chk (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      cfg_we,
  input wire logic [ffp_pkg::TOL_W-1:0] cfg_wdata,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire ffp_pkg::ffp_in_t          in_data,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire ffp_pkg::ffp_out_t         out_data
);
  import ffp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_valid |->
      out_data.axis_x_x == '0 && out_data.axis_x_y == '0 && out_data.axis_x_z == '0 &&
      out_data.axis_y_x == '0 && out_data.axis_y_y == '0 && out_data.axis_y_z == '0 &&
      out_data.axis_z_x == '0 && out_data.axis_z_y == '0 && out_data.axis_z_z == '0)
    else $error("rejected frame carries nonzero axes");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_valid |->
      $signed(out_data.axis_z_z) <= 32'sd1073741824 &&
      $signed(out_data.axis_z_z) >= -32'sd1073741824 &&
      $signed(out_data.axis_x_x) <= 32'sd1073741824 &&
      $signed(out_data.axis_x_x) >= -32'sd1073741824)
    else $error("axis component out of unit range");

endmodule

bind frame_from_three_points ffp_chk u_ffp_chk (.*);
`default_nettype wire

### bench/frame_from_three_points_tb.sv
// Self-checking bench for frame_from_three_points: drives point triples and
// tolerance writes, predicts each frame in fixed point and checks every beat.
// Depends on ffp_pkg and the frame_from_three_points RTL.
`timescale 1ns / 1ps
module frame_from_three_points_tb;
  import ffp_pkg::*;

  typedef longint v3_t [3];

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 240;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  ffp_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  ffp_out_t         out_data;

  ffp_out_t         frame_q [$];
  logic [TOL_W-1:0] tol_shadow = TOL_RESET;
  bit               idle_en = 1'b1;
  bit               hold_req = 1'b0;
  int               hold_cnt = 0;
  int               stall_left = 0;
  int               run_left = 0;
  int               errors = 0;
  int               beats_in = 0;
  int               beats_out = 0;
  int               frames_ok = 0;
  int               quiet = 0;

  frame_from_three_points dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_vector(input v3_t v, output v3_t u);
    longint unsigned mag [3];
    longint unsigned top, sum, n, q;
    int len;
    top = 0;
    sum = 0;
    len = 0;
    u = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) return 1'b0;
    while (len < 64 && (top >> len) != 0) len++;
    for (int i = 0; i < 3; i++) begin
      if (len > 30) mag[i] >>= (len - 30);
      else mag[i] <<= (30 - len);
      sum += mag[i] * mag[i];
    end
    n = sqrt_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 30) + (n >> 1)) / n;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic v3_t cross3(v3_t a, v3_t b);
    v3_t c;
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    return c;
  endfunction

  function automatic ffp_out_t build_frame(ffp_in_t b, logic [TOL_W-1:0] tol);
    v3_t ex, ey, ux, uy, uz, fy;
    longint dot;
    longint unsigned dmag;
    bit ok;
    ffp_out_t r;
    ex[0] = longint'(b.xdir_point_x) - longint'(b.origin_x);
    ex[1] = longint'(b.xdir_point_y) - longint'(b.origin_y);
    ex[2] = longint'(b.xdir_point_z) - longint'(b.origin_z);
    ey[0] = longint'(b.ydir_point_x) - longint'(b.origin_x);
    ey[1] = longint'(b.ydir_point_y) - longint'(b.origin_y);
    ey[2] = longint'(b.ydir_point_z) - longint'(b.origin_z);
    ok = unit_vector(ex, ux);
    if (ok) ok = unit_vector(ey, uy);
    if (ok) begin
      dot = ux[0] * uy[0] + ux[1] * uy[1] + ux[2] * uy[2];
      dmag = (dot < 0) ? -dot : dot;
      dmag = (dmag + (Q30_ONE >> 1)) >> 30;
      if (dmag > Q30_ONE) ok = 1'b0;
      else if ((Q30_ONE - dmag) < 64'(tol)) ok = 1'b0;
    end
    if (ok) ok = unit_vector(cross3(ux, uy), uz);
    if (ok) ok = unit_vector(cross3(uz, ux), fy);
    r = '0;
    if (ok) begin
      r.axis_x_x = q30_t'(ux[0]);
      r.axis_x_y = q30_t'(ux[1]);
      r.axis_x_z = q30_t'(ux[2]);
      r.axis_y_x = q30_t'(fy[0]);
      r.axis_y_y = q30_t'(fy[1]);
      r.axis_y_z = q30_t'(fy[2]);
      r.axis_z_x = q30_t'(uz[0]);
      r.axis_z_y = q30_t'(uz[1]);
      r.axis_z_z = q30_t'(uz[2]);
      r.frame_valid = 1'b1;
    end
    return r;
  endfunction

  function automatic ffp_in_t pack_points(longint o0, longint o1, longint o2,
                                          longint x0, longint x1, longint x2,
                                          longint y0, longint y1, longint y2);
    ffp_in_t b;
    b.origin_x = coord_t'(o0);
    b.origin_y = coord_t'(o1);
    b.origin_z = coord_t'(o2);
    b.xdir_point_x = coord_t'(x0);
    b.xdir_point_y = coord_t'(x1);
    b.xdir_point_z = coord_t'(x2);
    b.ydir_point_x = coord_t'(y0);
    b.ydir_point_y = coord_t'(y1);
    b.ydir_point_z = coord_t'(y2);
    return b;
  endfunction

  function automatic longint small_offset(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic ffp_in_t random_points();
    ffp_in_t b;
    longint o0, o1, o2, e0, e1, e2, k;
    int span;
    o0 = longint'(coord_t'($urandom));
    o1 = longint'(coord_t'($urandom));
    o2 = longint'(coord_t'($urandom));
    span = 1 << $urandom_range(0, 24);
    case ($urandom_range(0, 9))
      0, 1: begin
        b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
      end
      2, 3: begin
        // nearly parallel: y edge is a scaled x edge plus a small nudge
        e0 = small_offset(span);
        e1 = small_offset(span);
        e2 = small_offset(span);
        k = small_offset(3);
        b = pack_points(o0, o1, o2, o0 + e0, o1 + e1, o2 + e2,
                        o0 + k * e0 + small_offset(2), o1 + k * e1 + small_offset(2),
                        o2 + k * e2 + small_offset(2));
      end
      4: begin
        b = pack_points(o0, o1, o2, o0 + small_offset(1), o1 + small_offset(1),
                        o2 + small_offset(1), o0 + small_offset(1),
                        o1 + small_offset(1), o2 + small_offset(1));
      end
      default: begin
        b = pack_points(o0, o1, o2, o0 + small_offset(span), o1 + small_offset(span),
                        o2 + small_offset(span), o0 + small_offset(span),
                        o1 + small_offset(span), o2 + small_offset(span));
      end
    endcase
    return b;
  endfunction

  task automatic send_beat(ffp_in_t b);
    int gap;
    gap = (idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    frame_q.push_back(build_frame(b, tol_shadow));
    beats_in++;
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] v);
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_shadow = v;
  endtask

  task automatic send_random(int count);
    repeat (count) send_beat(random_points());
  endtask

  task automatic test_directed_cases();
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    send_beat(pack_points(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(pack_points(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    send_beat(pack_points(0, 0, 0, 0, 65536, 0, 0, 0, 65536));
    send_beat(pack_points(5, 6, 7, 5, 6, 7, 9, 9, 9));
    send_beat(pack_points(5, 6, 7, 9, 9, 9, 5, 6, 7));
    send_beat(pack_points(0, 0, 0, 3, 4, 5, 6, 8, 10));
    send_beat(pack_points(0, 0, 0, 3, 4, 5, -3, -4, -5));
    send_beat(pack_points(0, 0, 0, 1000000, 1, 0, 1000000, 2, 0));
    send_beat(pack_points(mn, mn, mn, mx, mn, mn, mn, mx, mn));
    send_beat(pack_points(mx, mx, mx, mn, mx, mx, mx, mx, mn));
    send_beat(pack_points(mn, mx, mn, mx, mn, mx, mn, mn, mx));
    send_beat(pack_points(mx, mn, mx, mn, mx, mn, mx, mx, mn));
    send_beat(pack_points(-1, -1, -1, 0, -1, -1, -1, 0, -1));
    send_beat(pack_points(123, -456, 789, 123 + 7, -456 - 3, 789, 123 + 1, -456, 789 + 9));
  endtask

  task automatic test_tolerance_extremes();
    write_tolerance('0);
    send_beat(pack_points(0, 0, 0, 3, 4, 5, 6, 8, 10));
    send_beat(pack_points(0, 0, 0, 1000000, 1, 0, 1000000, 2, 0));
    send_beat(pack_points(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    write_tolerance(TOL_W'(Q30_ONE));
    send_beat(pack_points(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    send_beat(pack_points(0, 0, 0, 65536, 0, 0, 65536, 65536, 0));
    write_tolerance(TOL_W'(Q30_ONE + 1));
    send_beat(pack_points(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    write_tolerance({TOL_W{1'b1}});
    send_beat(pack_points(0, 0, 0, 0, 65536, 0, 0, 0, 65536));
    send_random(4);
  endtask

  task automatic test_random_tolerances();
    logic [TOL_W-1:0] t;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: t = TOL_RESET;
        1: t = '0;
        2: t = TOL_W'($urandom_range(0, 1 << 12));
        3: t = TOL_W'($urandom_range(0, 1 << 30));
        4: t = TOL_W'($urandom);
        default: t = TOL_W'($urandom_range(1 << 20, 1 << 28));
      endcase
      write_tolerance(t);
      send_random(60);
    end
  endtask

  task automatic test_backpressure();
    write_tolerance(TOL_RESET);
    hold_req = 1'b1;
    for (int i = 0; i < 300; i++) begin
      in_valid <= 1'b1;
      in_data <= random_points();
      do @(posedge clk); while (in_stall);
      frame_q.push_back(build_frame(in_data, tol_shadow));
      beats_in++;
    end
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    write_tolerance(TOL_W'($urandom_range(0, 1 << 16)));
    send_random(120);
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      beats_out++;
      if (frame_q.size() == 0) begin
        $error("result beat with no frame expected");
        errors++;
      end else begin
        ffp_out_t exp_f;
        exp_f = frame_q.pop_front();
        if (out_data.frame_valid) frames_ok++;
        if (exp_f.axis_x_x !== out_data.axis_x_x)
          begin $error("axis_x_x exp %0d got %0d", exp_f.axis_x_x, out_data.axis_x_x); errors++; end
        if (exp_f.axis_x_y !== out_data.axis_x_y)
          begin $error("axis_x_y exp %0d got %0d", exp_f.axis_x_y, out_data.axis_x_y); errors++; end
        if (exp_f.axis_x_z !== out_data.axis_x_z)
          begin $error("axis_x_z exp %0d got %0d", exp_f.axis_x_z, out_data.axis_x_z); errors++; end
        if (exp_f.axis_y_x !== out_data.axis_y_x)
          begin $error("axis_y_x exp %0d got %0d", exp_f.axis_y_x, out_data.axis_y_x); errors++; end
        if (exp_f.axis_y_y !== out_data.axis_y_y)
          begin $error("axis_y_y exp %0d got %0d", exp_f.axis_y_y, out_data.axis_y_y); errors++; end
        if (exp_f.axis_y_z !== out_data.axis_y_z)
          begin $error("axis_y_z exp %0d got %0d", exp_f.axis_y_z, out_data.axis_y_z); errors++; end
        if (exp_f.axis_z_x !== out_data.axis_z_x)
          begin $error("axis_z_x exp %0d got %0d", exp_f.axis_z_x, out_data.axis_z_x); errors++; end
        if (exp_f.axis_z_y !== out_data.axis_z_y)
          begin $error("axis_z_y exp %0d got %0d", exp_f.axis_z_y, out_data.axis_z_y); errors++; end
        if (exp_f.axis_z_z !== out_data.axis_z_z)
          begin $error("axis_z_z exp %0d got %0d", exp_f.axis_z_z, out_data.axis_z_z); errors++; end
        if (exp_f.frame_valid !== out_data.frame_valid) begin
          $error("frame_valid exp %0b got %0b", exp_f.frame_valid, out_data.frame_valid);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 700;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (!idle_en) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall <= 1'b0;
    end else begin
      stall_left = $urandom_range(1, 17);
      run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 30);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("frame_from_three_points regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_tolerance_extremes();
    test_random_tolerances();
    test_backpressure();
    test_full_rate();
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d point triples, %0d frames back, %0d of them valid", beats_in,
             beats_out, frames_ok);
    $display("tolerance swept over reset, zero, one, above one and random values");
    if (errors == 0) begin
      $display("frame_from_three_points regression: pass");
    end else begin
      $display("frame_from_three_points regression: fail");
    end
    $finish;
  end

endmodule
